FILE: rtl/core/euler_totient_and_root_prime_count_top_defines.svh
// Assertion macros for the totient and root prime count block.
// Used by the top level only; no other dependencies.
`ifndef EULER_TOTIENT_AND_ROOT_PRIME_COUNT_TOP_DEFINES_SVH
`define EULER_TOTIENT_AND_ROOT_PRIME_COUNT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ETRPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ETRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/etrpc_pkg.sv
// Package of the totient and root prime count block: widths and sizes.
// No dependencies.
`timescale 1ns / 1ps

package etrpc_pkg;
  localparam int VALUE_W     = 32;
  localparam int TOTIENT_W   = 32;
  localparam int COUNT_W     = 13;
  localparam int PRIME_W     = 16;
  localparam int ROOT_LIMIT  = 65536;
  localparam int SIEVE_DEPTH = ROOT_LIMIT / 2;
  localparam int SIEVE_AW    = $clog2(SIEVE_DEPTH);
  localparam int PRIME_SLOTS = 8192;
  localparam int PRIME_AW    = $clog2(PRIME_SLOTS);
  localparam int TOTAL_W     = $clog2(PRIME_SLOTS + 1);
  localparam int DIV_STEPS   = VALUE_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS);
endpackage

FILE: rtl/core/etrpc_if.sv
// Request and result channel interfaces of the totient block.
// Depends on etrpc_pkg.
`timescale 1ns / 1ps

interface etrpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [etrpc_pkg::VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface etrpc_out_if;
  logic                            valid;
  logic                            ready;
  logic [etrpc_pkg::TOTIENT_W-1:0] totient;
  logic [etrpc_pkg::COUNT_W-1:0]   root_prime_count;
  modport source (output valid, output totient, output root_prime_count, input ready);
  modport sink (input valid, input totient, input root_prime_count, output ready);
endinterface

FILE: rtl/core/euler_totient_and_root_prime_count_top.sv
// Top level of the Euler totient and root prime count block.
// Depends on etrpc_pkg, etrpc_if, etrpc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "euler_totient_and_root_prime_count_top_defines.svh"

// Usage:
// A request on in_i carries a value x. One result per request leaves on
// channel out_o: the totient phi(x) and the count of primes not above
// floor(sqrt(x)). Values zero and one give totient x and count 0.
// After reset the block clears its 32768-entry sieve memory, then sieves
// the odd numbers below 65536 and writes the prime list. in_i.ready stays
// low until that is done. One request is worked on at a time. Factors of
// two are stripped one at a time. Each listed odd prime then gets a square
// test and, while its square is not above x, trial divisions in the
// bit-serial divider, which sets the pace: up to 6541 primes. The integer
// square root follows, and the prime count scan walks the listed primes
// not above the root through the prime list memory read port. A finished
// result sits in an output register; while the receiver stalls, the block
// finishes the next request and then waits.
module euler_totient_and_root_prime_count_top (
  input logic         clk_i,
  input logic         rst_ni,
  etrpc_in_if.sink    in_i,
  etrpc_out_if.source out_o
);
  localparam int VW = etrpc_pkg::VALUE_W;
  localparam int PW = etrpc_pkg::PRIME_W;
  localparam int TW = etrpc_pkg::TOTAL_W;

  typedef enum logic [4:0] {
    S_CLEAR, S_SCAN_RD, S_SCAN_CHK, S_MARK_WAIT, S_MARK_CHK, S_MARK, S_SCAN_NEXT,
    S_IDLE, S_STRIP, S_PRIME_RD, S_PRIME_GOT, S_SQ_WAIT, S_SQ_CHK, S_DIV,
    S_DIV_END, S_PHI_WAIT, S_PHI_SET, S_LEFT, S_LEFT_WAIT, S_LEFT_SET,
    S_SQRT, S_CNT_RD, S_CNT_CHK, S_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic [etrpc_pkg::SIEVE_AW-1:0] clr_q, clr_d, si_q, si_d;
  logic [TW-1:0]              total_q, total_d, idx_q, idx_d;
  logic [VW-1:0]              x_q, x_d, phi_q, phi_d;
  logic                       twos_q, twos_d, first_q, first_d;
  logic [PW-1:0]              p_q, p_d;
  logic [VW-1:0]              dq_q, dq_d;
  logic [PW:0]                rem_q, rem_d;
  logic [etrpc_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [VW-1:0]              a_q, a_d, b_q, b_d, prod_q;
  logic [2*VW-1:0]            prod_full;
  logic [PW:0]                j_q, j_d;
  logic [VW-1:0]              sv_q, sv_d, root_q, root_d, bit_q, bit_d;
  logic                       ov_q, ov_d;
  logic [etrpc_pkg::TOTIENT_W-1:0] otot_q, otot_d;
  logic [etrpc_pkg::COUNT_W-1:0]   ocnt_q, ocnt_d;

  // Memory ports.
  logic                           s_we, s_wdata, s_rdata;
  logic [etrpc_pkg::SIEVE_AW-1:0] s_waddr;
  logic                           p_we;
  logic [etrpc_pkg::PRIME_AW-1:0] p_waddr;
  logic [PW-1:0]                  p_wdata, p_rdata;

  // Helper values.
  logic [PW:0] div_trial;
  logic [VW-1:0] sq_sum;
  logic accept;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = ov_q;
  assign out_o.totient = otot_q;
  assign out_o.root_prime_count = ocnt_q;

  assign prod_full = a_q * b_q;
  assign div_trial = {rem_q[PW-1:0], dq_q[VW-1]};
  assign sq_sum    = root_q + bit_q;

  etrpc_ram #(.WIDTH(1), .DEPTH(etrpc_pkg::SIEVE_DEPTH)) u_sieve_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (si_q),
    .rdata_o (s_rdata)
  );

  etrpc_ram #(.WIDTH(PW), .DEPTH(etrpc_pkg::PRIME_SLOTS)) u_prime_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (idx_q[etrpc_pkg::PRIME_AW-1:0]),
    .rdata_o (p_rdata)
  );

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;  si_d = si_q;  total_d = total_q;  idx_d = idx_q;
    x_d = x_q;  phi_d = phi_q;  twos_d = twos_q;  first_d = first_q;
    p_d = p_q;  dq_d = dq_q;  rem_d = rem_q;  dcnt_d = dcnt_q;
    a_d = a_q;  b_d = b_q;  j_d = j_q;
    sv_d = sv_q;  root_d = root_q;  bit_d = bit_q;
    ov_d = ov_q;  otot_d = otot_q;  ocnt_d = ocnt_q;
    s_we = 1'b0;  s_waddr = clr_q;  s_wdata = 1'b0;
    p_we = 1'b0;  p_waddr = total_q[etrpc_pkg::PRIME_AW-1:0];  p_wdata = p_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      // Clearing pass; entry zero (the number one) is marked composite.
      S_CLEAR: begin
        s_we = 1'b1;
        s_waddr = clr_q;
        s_wdata = (clr_q == '0);
        if (clr_q == '0) begin
          p_we = 1'b1;
          p_waddr = '0;
          p_wdata = PW'(2);
          total_d = TW'(1);
        end
        if (clr_q == etrpc_pkg::SIEVE_AW'(etrpc_pkg::SIEVE_DEPTH - 1)) begin
          si_d = etrpc_pkg::SIEVE_AW'(1);
          state_d = S_SCAN_RD;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (s_rdata) begin
          state_d = S_SCAN_NEXT;
        end else begin
          p_d = {si_q, 1'b1};
          if (total_q < TW'(etrpc_pkg::PRIME_SLOTS)) begin
            p_we = 1'b1;
            p_wdata = {si_q, 1'b1};
            total_d = total_q + 1'b1;
          end
          a_d = VW'({si_q, 1'b1});
          b_d = VW'({si_q, 1'b1});
          state_d = S_MARK_WAIT;
        end
      end
      S_MARK_WAIT: state_d = S_MARK_CHK;
      S_MARK_CHK: begin
        if (prod_q < VW'(etrpc_pkg::ROOT_LIMIT)) begin
          j_d = prod_q[PW:0];
          state_d = S_MARK;
        end else begin
          state_d = S_SCAN_NEXT;
        end
      end
      S_MARK: begin
        if (!j_q[PW]) begin
          s_we = 1'b1;
          s_waddr = j_q[PW-1:1];
          s_wdata = 1'b1;
          j_d = j_q + {p_q, 1'b0};
        end else begin
          state_d = S_SCAN_NEXT;
        end
      end
      S_SCAN_NEXT: begin
        if (si_q == etrpc_pkg::SIEVE_AW'(etrpc_pkg::SIEVE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          si_d = si_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_IDLE: begin
        if (accept) begin
          sv_d = in_i.value;
          root_d = '0;
          bit_d = VW'(1) << (VW - 2);
          x_d = in_i.value;
          twos_d = 1'b0;
          if (in_i.value <= VW'(1)) begin
            phi_d = in_i.value;
            state_d = S_SQRT;
          end else begin
            phi_d = VW'(1);
            state_d = S_STRIP;
          end
        end
      end
      // One factor of two per cycle; phi doubles for every factor after the first.
      S_STRIP: begin
        if (!x_q[0]) begin
          x_d = x_q >> 1;
          twos_d = 1'b1;
          if (twos_q) begin
            phi_d = phi_q << 1;
          end
        end else begin
          idx_d = TW'(1);
          state_d = S_PRIME_RD;
        end
      end
      S_PRIME_RD: state_d = (idx_q < total_q) ? S_PRIME_GOT : S_LEFT;
      S_PRIME_GOT: begin
        if (p_rdata < PW'(2)) begin
          state_d = S_LEFT;
        end else begin
          p_d = p_rdata;
          a_d = VW'(p_rdata);
          b_d = VW'(p_rdata);
          state_d = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: state_d = S_SQ_CHK;
      S_SQ_CHK: begin
        if (prod_q > x_q) begin
          state_d = S_LEFT;
        end else begin
          dq_d = x_q;
          rem_d = '0;
          dcnt_d = etrpc_pkg::DCNT_W'(etrpc_pkg::DIV_STEPS - 1);
          first_d = 1'b1;
          state_d = S_DIV;
        end
      end
      // Restoring divider, one quotient bit per cycle.
      S_DIV: begin
        if (div_trial >= {1'b0, p_q}) begin
          rem_d = div_trial - {1'b0, p_q};
          dq_d = {dq_q[VW-2:0], 1'b1};
        end else begin
          rem_d = div_trial;
          dq_d = {dq_q[VW-2:0], 1'b0};
        end
        if (dcnt_q == '0) begin
          state_d = S_DIV_END;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      S_DIV_END: begin
        if (rem_q != '0) begin
          idx_d = idx_q + 1'b1;
          state_d = S_PRIME_RD;
        end else begin
          x_d = dq_q;
          a_d = phi_q;
          b_d = first_q ? VW'(p_q - 1'b1) : VW'(p_q);
          state_d = S_PHI_WAIT;
        end
      end
      S_PHI_WAIT: state_d = S_PHI_SET;
      S_PHI_SET: begin
        phi_d = prod_q;
        dq_d = x_q;
        rem_d = '0;
        dcnt_d = etrpc_pkg::DCNT_W'(etrpc_pkg::DIV_STEPS - 1);
        first_d = 1'b0;
        state_d = S_DIV;
      end
      S_LEFT: begin
        if (x_q > VW'(1)) begin
          a_d = phi_q;
          b_d = x_q - 1'b1;
          state_d = S_LEFT_WAIT;
        end else begin
          state_d = S_SQRT;
        end
      end
      S_LEFT_WAIT: state_d = S_LEFT_SET;
      S_LEFT_SET: begin
        phi_d = prod_q;
        state_d = S_SQRT;
      end
      // Digit-by-digit square root, two radicand bits per cycle.
      S_SQRT: begin
        if (bit_q != '0) begin
          if (sv_q >= sq_sum) begin
            sv_d = sv_q - sq_sum;
            root_d = (root_q >> 1) + bit_q;
          end else begin
            root_d = root_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else begin
          idx_d = '0;
          state_d = S_CNT_RD;
        end
      end
      S_CNT_RD: state_d = (idx_q < total_q) ? S_CNT_CHK : S_DONE;
      S_CNT_CHK: begin
        if (VW'(p_rdata) <= root_q) begin
          idx_d = idx_q + 1'b1;
          state_d = S_CNT_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;
          otot_d = phi_q;
          ocnt_d = idx_q[etrpc_pkg::COUNT_W-1:0];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      si_q    <= '0;
      total_q <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      si_q    <= si_d;
      total_q <= total_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;  phi_q <= phi_d;  twos_q <= twos_d;  first_q <= first_d;
    p_q <= p_d;  dq_q <= dq_d;  rem_q <= rem_d;  dcnt_q <= dcnt_d;
    a_q <= a_d;  b_q <= b_d;  prod_q <= prod_full[VW-1:0];  j_q <= j_d;
    sv_q <= sv_d;  root_q <= root_d;  bit_q <= bit_d;
    otot_q <= otot_d;  ocnt_q <= ocnt_d;
  end

  // A request is taken only when idle, so the next cycle never takes another.
  `ETRPC_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, accept, !in_i.ready)
  // Trial division only reads list entries that the sieve has written.
  `ETRPC_ASSERT_NOW(a_list_read_in_range, clk_i, rst_ni, state_q == S_PRIME_GOT, idx_q < total_q)
  // The prime count never passes the list capacity.
  `ETRPC_ASSERT_NOW(a_total_bound, clk_i, rst_ni, 1'b1, total_q <= TW'(etrpc_pkg::PRIME_SLOTS))
endmodule

FILE: rtl/core/etrpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module etrpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
